// File: hdl/tta_pkg.sv
package tta_pkg;

	// Number of channels with their own history entry.
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Input commands.
	localparam logic [1:0] CMD_SCALE   = 2'd0;
	localparam logic [1:0] CMD_SAMPLE  = 2'd1;
	localparam logic [1:0] CMD_PRELOAD = 2'd2;

	// Coding modes.
	localparam logic [2:0] MODE_FIXED  = 3'd2;
	localparam logic [2:0] MODE_LINEAR = 3'd3;
	localparam logic [2:0] MODE_EXP    = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_CODING_MODE   = 3'd0;
	localparam logic [2:0] REG_CODE_BITS     = 3'd1;
	localparam logic [2:0] REG_BLOCK_SAMPLES = 3'd2;
	localparam logic [2:0] REG_COEF_NEWER    = 3'd3;
	localparam logic [2:0] REG_COEF_OLDER    = 3'd4;

	// Channel-0 scale word that terminates the stream.
	localparam logic [15:0] END_WORD = 16'h8001;

	// Output clamp limits.
	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	// Work carried from the accept cycle into the history stage.
	typedef struct packed {
		logic                     sample;
		logic                     preload;
		logic [CH_W-1:0]          ch;
		logic signed [33:0]       sprod;
		logic signed [15:0]       wn;
		logic signed [15:0]       wo;
		logic                     last;
		logic signed [15:0]       pre_newer;
		logic signed [15:0]       pre_older;
	} s1_item_t;

	// Fixed coefficient pairs for the fixed predictor table, newer tap in the upper half.
	function automatic logic [31:0] fixed_pair(input logic [1:0] pick);
		logic [31:0] pair;
		case (pick)
			2'd0: pair = {16'h0000, 16'h0000};
			2'd1: pair = {16'h0F00, 16'h0000};
			2'd2: pair = {16'h1CC0, 16'hF300};
			2'd3: pair = {16'h1880, 16'hF240};
			default: pair = '0;
		endcase
		return pair;
	endfunction

endpackage

// File: hdl/tta_predict.sv
// Two-tap prediction: weighted history taps, each floored by 12 bits, plus the
// scaled code, clamped to 16 bits.
module tta_predict (
	input  tta_pkg::s1_item_t  item,
	input  logic signed [15:0] hist_newer,
	input  logic signed [15:0] hist_older,
	output logic signed [15:0] pcm
);

	logic signed [31:0] prod_newer;
	logic signed [31:0] prod_older;
	logic signed [31:0] tap_newer;
	logic signed [31:0] tap_older;
	logic signed [34:0] acc;

	assign prod_newer = item.wn * hist_newer;
	assign prod_older = item.wo * hist_older;
	assign tap_newer  = prod_newer >>> 12;
	assign tap_older  = prod_older >>> 12;
	assign acc        = 35'(item.sprod) + 35'(tap_newer) + 35'(tap_older);

	always_comb begin
		if (acc > 35'(tta_pkg::PCM_MAX)) begin
			pcm = tta_pkg::PCM_MAX;
		end else if (acc < 35'(tta_pkg::PCM_MIN)) begin
			pcm = tta_pkg::PCM_MIN;
		end else begin
			pcm = acc[15:0];
		end
	end

endmodule

// File: hdl/two_tap_adpcm_block_decoder_core.sv
// Channel      | Direction | Handshake             | Payload
// cfg          | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// in           | in        | in_valid / in_ready   | command, channel, word, preload_newer,
//              |           |                       | preload_older
// out          | out       | out_valid / out_ready | pcm_sample, sample_channel, last_in_block
//
// One word is taken per clock cycle except during a stall. The accepting edge of a coded
// sample also reads its history entry; the history stage runs the multiply-add and loads
// the output register. Reset clears all control state and marks every history entry as
// unwritten, so an unwritten entry reads as zero; there is no clearing pass.
// The input stalls only while a decoded sample waits in the history stage behind a
// full output register that is not being drained.
module two_tap_adpcm_block_decoder_core (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [2:0]         channel,
	input  logic [15:0]        word,
	input  logic signed [15:0] preload_newer,
	input  logic signed [15:0] preload_older,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pcm_sample,
	output logic [2:0]         sample_channel,
	output logic               last_in_block
);

	// Configuration registers.
	logic [2:0]         coding_mode_q;
	logic [3:0]         code_bits_q;
	logic [9:0]         block_samples_q;
	logic signed [15:0] coef_newer_q;
	logic signed [15:0] coef_older_q;

	// Block state, updated when a word is accepted.
	logic [tta_pkg::CH_W-1:0] cur_ch_q;
	logic [16:0]              step_q;
	logic signed [15:0]       wn_q;
	logic signed [15:0]       wo_q;
	logic [9:0]               samples_left_q;
	logic                     stream_ended_q;

	// History memory: newer tap in the upper half, older tap in the lower half.
	logic [31:0]                       hist_mem [tta_pkg::MAX_CHANNELS];
	logic [tta_pkg::MAX_CHANNELS-1:0]  hist_vld_q;
	logic [31:0]                       rd_data_q;
	logic                              rd_vld_q;

	// Last memory write, kept for the item that read the memory at that same edge.
	logic                     wb_valid_q;
	logic [tta_pkg::CH_W-1:0] wb_ch_q;
	logic [31:0]              wb_data_q;

	tta_pkg::s1_item_t s1_q;
	logic              s1_valid_q;
	tta_pkg::s1_item_t s1_next;

	logic out_valid_q;

	logic        in_acc;
	logic        advance;
	logic        ch_ok;
	logic        end_word;
	logic        scale_go;
	logic        sample_go;
	logic        preload_go;
	logic [16:0] new_step;
	logic [31:0] new_pair;
	logic [3:0]  bits_eff;
	logic [3:0]  sh;
	logic [15:0] code_shl;
	logic signed [15:0] code_val;

	logic signed [15:0] hist_newer;
	logic signed [15:0] hist_older;
	logic signed [15:0] pcm_s1;
	logic               wr_en;
	logic [31:0]        wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coding_mode_q   <= tta_pkg::MODE_LINEAR;
			code_bits_q     <= 4'd4;
			block_samples_q <= 10'd32;
			coef_newer_q    <= '0;
			coef_older_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tta_pkg::REG_CODING_MODE:   coding_mode_q   <= cfg_data[2:0];
				tta_pkg::REG_CODE_BITS:     code_bits_q     <= cfg_data[3:0];
				tta_pkg::REG_BLOCK_SAMPLES: block_samples_q <= cfg_data[9:0];
				tta_pkg::REG_COEF_NEWER:    coef_newer_q    <= cfg_data;
				tta_pkg::REG_COEF_OLDER:    coef_older_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline only holds when a sample has nowhere to go.
	assign advance  = !(s1_valid_q && s1_q.sample && out_valid_q && !out_ready);
	assign in_ready = advance;
	assign in_acc   = in_valid && in_ready;

	assign ch_ok      = 32'(channel) < tta_pkg::MAX_CHANNELS;
	assign end_word   = (channel == 3'd0) && (word == tta_pkg::END_WORD);
	assign scale_go   = in_acc && (command == tta_pkg::CMD_SCALE) && !stream_ended_q && ch_ok;
	assign sample_go  = in_acc && (command == tta_pkg::CMD_SAMPLE) && !stream_ended_q
		&& (samples_left_q != '0);
	assign preload_go = in_acc && (command == tta_pkg::CMD_PRELOAD) && ch_ok;

	// Step multiplier and weights selected by a scale word.
	always_comb begin
		new_pair = {coef_newer_q, coef_older_q};
		case (coding_mode_q)
			tta_pkg::MODE_EXP: begin
				if (word > 16'd12) begin
					new_step = 17'd1;
				end else begin
					new_step = 17'd1 << (4'd12 - word[3:0]);
				end
			end
			tta_pkg::MODE_FIXED: begin
				new_step = 17'(word[12:0]) + 17'd1;
				new_pair = tta_pkg::fixed_pair(word[14:13]);
			end
			default: begin
				new_step = 17'(word) + 17'd1;
			end
		endcase
	end

	// Sign extension of the coded sample from its code width, at least two bits.
	assign bits_eff = (code_bits_q < 4'd2) ? 4'd2 : code_bits_q;
	assign sh       = 4'(5'd16 - {1'b0, bits_eff});
	assign code_shl = word << sh;
	assign code_val = $signed(code_shl) >>> sh;

	always_comb begin
		s1_next           = '0;
		s1_next.sample    = sample_go;
		s1_next.preload   = preload_go;
		s1_next.ch        = sample_go ? cur_ch_q : channel[tta_pkg::CH_W-1:0];
		s1_next.sprod     = code_val * $signed({1'b0, step_q});
		s1_next.wn        = wn_q;
		s1_next.wo        = wo_q;
		s1_next.last      = samples_left_q == 10'd1;
		s1_next.pre_newer = preload_newer;
		s1_next.pre_older = preload_older;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ch_q       <= '0;
			step_q         <= 17'd1;
			wn_q           <= '0;
			wo_q           <= '0;
			samples_left_q <= '0;
			stream_ended_q <= 1'b0;
		end else if (scale_go) begin
			if (end_word) begin
				stream_ended_q <= 1'b1;
				samples_left_q <= '0;
			end else begin
				cur_ch_q       <= channel[tta_pkg::CH_W-1:0];
				step_q         <= new_step;
				wn_q           <= new_pair[31:16];
				wo_q           <= new_pair[15:0];
				samples_left_q <= block_samples_q;
			end
		end else if (sample_go) begin
			samples_left_q <= samples_left_q - 10'd1;
		end
	end

	// History stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= sample_go || preload_go;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s1_q <= s1_next;
		end
	end

	// Memory read, registered, issued as a sample is accepted.
	always_ff @(posedge clk) begin
		if (sample_go) begin
			rd_data_q <= hist_mem[cur_ch_q];
		end
		if (wr_en) begin
			hist_mem[s1_q.ch] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (sample_go) begin
				rd_vld_q <= hist_vld_q[cur_ch_q];
			end
			if (wr_en) begin
				hist_vld_q[s1_q.ch] <= 1'b1;
			end
		end
	end

	// A write at the edge that read this item's entry is not in the read data yet.
	always_comb begin
		if (wb_valid_q && (wb_ch_q == s1_q.ch)) begin
			hist_newer = wb_data_q[31:16];
			hist_older = wb_data_q[15:0];
		end else if (rd_vld_q) begin
			hist_newer = rd_data_q[31:16];
			hist_older = rd_data_q[15:0];
		end else begin
			hist_newer = '0;
			hist_older = '0;
		end
	end

	tta_predict u_predict (
		.item       (s1_q),
		.hist_newer (hist_newer),
		.hist_older (hist_older),
		.pcm        (pcm_s1)
	);

	assign wr_en   = s1_valid_q && advance;
	assign wr_data = s1_q.sample ? {pcm_s1, hist_newer} : {s1_q.pre_newer, s1_q.pre_older};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (advance) begin
			wb_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wb_ch_q   <= s1_q.ch;
			wb_data_q <= wr_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && s1_q.sample && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_q.sample && advance) begin
			pcm_sample     <= pcm_s1;
			sample_channel <= 3'(s1_q.ch);
			last_in_block  <= s1_q.last;
		end
	end

	assign out_valid = out_valid_q;

	// A coded sample outside an open block must not reach the history stage.
	a_skip_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == tta_pkg::CMD_SAMPLE)
		&& ((samples_left_q == '0) || stream_ended_q)
		|=> !(s1_valid_q && s1_q.sample))
		else $error("sample outside a block entered the history stage");

	// A blocked sample stays in the history stage with its channel.
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_q.sample && out_valid && !out_ready
		|=> s1_valid_q && s1_q.sample && $stable(s1_q.ch))
		else $error("stalled sample lost from the history stage");

	// Once ended, the stream stays ended with no samples left.
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		stream_ended_q |=> stream_ended_q && (samples_left_q == '0))
		else $error("stream end state changed");

endmodule

// File: sim/adpcm_decode_check_pkg.sv
package adpcm_decode_check_pkg;

	typedef struct {
		logic signed [15:0] pcm;
		logic [2:0]         ch;
		logic               last;
	} pcm_word_t;

	// Tracks the decoder state from the words it accepts and keeps the decoded
	// samples that are still owed on the output.
	class adpcm_decode_scoreboard;

		logic [2:0]         mode;
		logic [3:0]         bits;
		logic [9:0]         blk_len;
		logic signed [15:0] coef_n;
		logic signed [15:0] coef_o;

		logic signed [15:0] hist_new [tta_pkg::MAX_CHANNELS];
		logic signed [15:0] hist_old [tta_pkg::MAX_CHANNELS];
		logic signed [15:0] fixed_new [4];
		logic signed [15:0] fixed_old [4];
		logic [2:0]         cur_ch;
		int                 step;
		logic signed [15:0] wt_new;
		logic signed [15:0] wt_old;
		logic [9:0]         left;
		bit                 ended;

		pcm_word_t owed[$];
		int        checked;
		int        mismatches;

		function new();
			fixed_new = '{16'sh0000, 16'sh0F00, 16'sh1CC0, 16'sh1880};
			fixed_old = '{16'sh0000, 16'sh0000, 16'shF300, 16'shF240};
			mode = tta_pkg::MODE_LINEAR;
			bits = 4'd4;
			blk_len = 10'd32;
			coef_n = '0;
			coef_o = '0;
			foreach (hist_new[i]) begin
				hist_new[i] = '0;
				hist_old[i] = '0;
			end
			cur_ch = '0;
			step = 1;
			wt_new = '0;
			wt_old = '0;
			left = '0;
			ended = 1'b0;
			checked = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				tta_pkg::REG_CODING_MODE:   mode = data[2:0];
				tta_pkg::REG_CODE_BITS:     bits = data[3:0];
				tta_pkg::REG_BLOCK_SAMPLES: blk_len = data[9:0];
				tta_pkg::REG_COEF_NEWER:    coef_n = data;
				tta_pkg::REG_COEF_OLDER:    coef_o = data;
				default: ;
			endcase
		endfunction

		function void note_input(logic [1:0] cmd, logic [2:0] ch, logic [15:0] w,
				logic signed [15:0] pn, logic signed [15:0] po);
			int        width;
			int        mask;
			logic [15:0] raw;
			longint    sval;
			longint    acc;
			pcm_word_t item;
			case (cmd)
				tta_pkg::CMD_SCALE: begin
					if (ended || ch >= tta_pkg::MAX_CHANNELS)
						return;
					if (ch == 0 && w == tta_pkg::END_WORD) begin
						ended = 1'b1;
						left = '0;
						return;
					end
					cur_ch = ch;
					if (mode == tta_pkg::MODE_EXP) begin
						step = (w > 12) ? 1 : (1 << (12 - w));
						wt_new = coef_n;
						wt_old = coef_o;
					end else if (mode == tta_pkg::MODE_FIXED) begin
						step = int'(w[12:0]) + 1;
						wt_new = fixed_new[w[14:13]];
						wt_old = fixed_old[w[14:13]];
					end else begin
						step = int'(w) + 1;
						wt_new = coef_n;
						wt_old = coef_o;
					end
					left = blk_len;
				end
				tta_pkg::CMD_PRELOAD: begin
					if (ch >= tta_pkg::MAX_CHANNELS)
						return;
					hist_new[ch] = pn;
					hist_old[ch] = po;
				end
				tta_pkg::CMD_SAMPLE: begin
					if (ended || left == 0)
						return;
					width = (bits < 2) ? 2 : int'(bits);
					mask = (1 << width) - 1;
					raw = w & mask[15:0];
					sval = raw;
					if (raw[width-1])
						sval -= longint'(1) << width;
					acc = sval * step
						+ ((longint'(wt_new) * longint'(hist_new[cur_ch])) >>> 12)
						+ ((longint'(wt_old) * longint'(hist_old[cur_ch])) >>> 12);
					if (acc > 32767)
						acc = 32767;
					if (acc < -32768)
						acc = -32768;
					hist_old[cur_ch] = hist_new[cur_ch];
					hist_new[cur_ch] = acc[15:0];
					left--;
					item.pcm = acc[15:0];
					item.ch = cur_ch;
					item.last = (left == 0);
					owed.push_back(item);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [15:0] pcm, logic [2:0] ch, logic last);
			pcm_word_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("decoded word with nothing outstanding: pcm %0d ch %0d last %0b",
						pcm, ch, last);
				return;
			end
			want = owed.pop_front();
			checked++;
			if (pcm !== want.pcm || ch !== want.ch || last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"decoded word %0d wrong: got pcm %0d ch %0d last %0b, ",
						"wanted pcm %0d ch %0d last %0b"},
						checked, pcm, ch, last, want.pcm, want.ch, want.last);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction

	endclass

endpackage

// File: sim/two_tap_adpcm_block_decoder_core_tb.sv
module two_tap_adpcm_block_decoder_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// The command code the block does not know; it must be swallowed silently.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	// A decoded sample passes through the history stage into the output register after
	// its coded sample is taken; SETTLE is the wait allowed before the registers are
	// touched or the run is closed.
	localparam int LATENCY = 1;
	localparam int SETTLE = LATENCY + 3;
	// Longest run of cycles with no word moving on any channel before giving up.
	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS = 165;

	logic clk = 1'b0;
	logic arst_n;

	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic [2:0]         channel;
	logic [15:0]        word;
	logic signed [15:0] preload_newer;
	logic signed [15:0] preload_older;

	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] pcm_sample;
	logic [2:0]         sample_channel;
	logic               last_in_block;

	adpcm_decode_check_pkg::adpcm_decode_scoreboard sb = new();

	// When set, neither the sender nor the receiver inserts any idle cycles.
	bit steady;
	// The coding mode and block length currently in force, used to shape stimulus.
	logic [2:0] cur_mode;
	logic [9:0] cur_blk;
	int words_in;
	int reg_writes;
	int settings;
	int idle_cycles;

	always #1 clk = ~clk;

	two_tap_adpcm_block_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.channel        (channel),
		.word           (word),
		.preload_newer  (preload_newer),
		.preload_older  (preload_older),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pcm_sample     (pcm_sample),
		.sample_channel (sample_channel),
		.last_in_block  (last_in_block)
	);

	// Sends one input word. The task is entered and left at a falling edge; valid
	// stays high across back-to-back words so that no zero-length drop appears.
	task automatic push_word(input logic [1:0] cmd, input logic [2:0] ch,
			input logic [15:0] w, input logic signed [15:0] pn,
			input logic signed [15:0] po);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		channel = ch;
		word = w;
		preload_newer = pn;
		preload_older = po;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(cmd, ch, w, pn, po);
		words_in++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Registers are only touched once every owed sample has come back and the
	// pipeline has had time to retire any preload or scale word still in flight.
	task automatic configure(input logic [2:0] mode, input logic [3:0] bits,
			input logic [9:0] blk, input logic [15:0] cn, input logic [15:0] co);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		write_reg(tta_pkg::REG_CODING_MODE, {13'd0, mode});
		write_reg(tta_pkg::REG_CODE_BITS, {12'd0, bits});
		write_reg(tta_pkg::REG_BLOCK_SAMPLES, {6'd0, blk});
		write_reg(tta_pkg::REG_COEF_NEWER, cn);
		write_reg(tta_pkg::REG_COEF_OLDER, co);
		cur_mode = mode;
		cur_blk = blk;
		settings++;
	endtask

	// Scale words are drawn so that linear and exponential modes spend most of their
	// time on steps that do not drive every sample straight into the clamp.
	function automatic logic [15:0] scale_word(input logic [2:0] mode);
		int r;
		r = $urandom_range(0, 9);
		case (mode)
			tta_pkg::MODE_EXP:   return (r < 7) ? 16'($urandom_range(0, 15)) : 16'($urandom);
			tta_pkg::MODE_FIXED: return 16'($urandom);
			default: begin
				if (r < 4)
					return 16'($urandom_range(0, 31));
				else if (r < 7)
					return 16'($urandom_range(0, 4095));
				return 16'($urandom);
			end
		endcase
	endfunction

	function automatic logic [15:0] history_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] mild_coef();
		int t;
		t = int'($urandom_range(0, 16'h3000)) - 16'h1800;
		return t[15:0];
	endfunction

	// One random phase: mostly complete blocks (scale word, then a block's worth of
	// coded samples), with preloads mixed in, some blocks cut short or overrun, and a
	// little noise. Overrun samples and unknown commands do not count toward budget.
	task automatic run_phase(input int budget);
		int         done;
		int         n;
		int         extra;
		int         r;
		logic [2:0] ch;
		logic [15:0] w;
		done = 0;
		while (done < budget) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_word(tta_pkg::CMD_PRELOAD, 3'($urandom), 16'($urandom),
					history_value(), history_value());
				done++;
			end else if (r < 11) begin
				push_word(CMD_UNKNOWN, 3'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			end else if (r < 13) begin
				push_word(tta_pkg::CMD_SAMPLE, 3'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			end else begin
				ch = 3'($urandom);
				w = scale_word(cur_mode);
				if (ch == 0 && w == tta_pkg::END_WORD)
					w = w ^ 16'h0001;
				push_word(tta_pkg::CMD_SCALE, ch, w, 16'($urandom), 16'($urandom));
				done++;
				n = cur_blk;
				extra = 0;
				r = $urandom_range(0, 9);
				if (r == 0)
					n = $urandom_range(0, n);
				else if (r == 1)
					extra = $urandom_range(1, 3);
				if (n > budget - done)
					n = budget - done;
				repeat (n) begin
					push_word(tta_pkg::CMD_SAMPLE, 3'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
					done++;
				end
				repeat (extra)
					push_word(tta_pkg::CMD_SAMPLE, 3'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
			end
		end
		in_valid = 1'b0;
	endtask

	// Output side: for every word a random stall is drawn unless steady is set, then ready
	// is held high until a decoded sample is taken.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(pcm_sample, sample_channel, last_in_block);
			@(negedge clk);
		end
	end

	// Watchdog: any word moving on any of the three channels counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (cfg_valid && cfg_ready)
				|| (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no word moved for %0d cycles", IDLE_LIMIT);
				$display("two_tap_adpcm_block_decoder_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0] mode;
		logic [3:0] bits;
		logic [9:0] blk;
		logic [15:0] cn;
		logic [15:0] co;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = '0;
		channel = '0;
		word = '0;
		preload_newer = '0;
		preload_older = '0;
		steady = 1'b0;
		cur_mode = tta_pkg::MODE_LINEAR;
		cur_blk = 10'd32;
		words_in = 0;
		reg_writes = 0;
		settings = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Linear mode with a unity newer weight and the lowest older weight, a channel
		// whose history sits at both clamp limits, and the widest linear step.
		configure(tta_pkg::MODE_LINEAR, 4'd4, 10'd3, 16'h1000, 16'h8000);
		// A coded sample before any block has been opened gives nothing.
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'h0005, 16'h0000, 16'h0000);
		push_word(CMD_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_word(tta_pkg::CMD_PRELOAD, 3'd7, 16'h0000, 16'h7FFF, 16'h8000);
		push_word(tta_pkg::CMD_SCALE, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'h0007, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'h0008, 16'h0000, 16'h0000);
		// Bits above code_bits must be ignored.
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'hFFF0, 16'h0000, 16'h0000);
		// The block is used up, so this one is dropped.
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'h0001, 16'h0000, 16'h0000);

		// Fixed table: every coefficient pair, the top step, bit 15 set on a scale
		// word, and a code width below the minimum that is widened to two bits.
		configure(tta_pkg::MODE_FIXED, 4'd0, 10'd2, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd2, 16'h0000, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd5, 16'h0001, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd2, 16'hA000, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd5, 16'h0002, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd2, 16'h5FFF, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd5, 16'h0003, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd5, 16'h7FFF, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd2, 16'h0001, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd2, 16'h0002, 16'h0000, 16'h0000);

		// Exponential mode with an empty block: the scale word opens nothing.
		configure(tta_pkg::MODE_EXP, 4'd15, 10'd0, 16'h7FFF, 16'h7FFF);
		push_word(tta_pkg::CMD_SCALE, 3'd1, 16'd13, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd1, 16'h4000, 16'h0000, 16'h0000);

		// A long block of 1012 samples, widest code, exponents at both ends of the table.
		configure(tta_pkg::MODE_EXP, 4'd15, 10'd1012, 16'h7FFF, 16'h8000);
		push_word(tta_pkg::CMD_SCALE, 3'd1, 16'd0, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd1, 16'h3FFF, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd1, 16'h4000, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd1, 16'd12, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd1, 16'h0001, 16'h0000, 16'h0000);
		in_valid = 1'b0;

		// Random phases walk through all three modes; the narrowest and widest code
		// widths, the one-sample block and the weight extremes each get a phase.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 3)
				0: mode = tta_pkg::MODE_LINEAR;
				1: mode = tta_pkg::MODE_EXP;
				default: mode = tta_pkg::MODE_FIXED;
			endcase
			bits = 4'($urandom_range(2, 15));
			blk = 10'($urandom_range(1, 24));
			cn = mild_coef();
			co = mild_coef();
			case (p)
				0: bits = 4'd2;
				1: begin
					bits = 4'd15;
					blk = 10'd1;
				end
				3: begin
					cn = 16'h7FFF;
					co = 16'h8000;
				end
				4: begin
					cn = 16'h8000;
					co = 16'h7FFF;
				end
				5: blk = 10'($urandom_range(25, 64));
				default: ;
			endcase
			configure(mode, bits, blk, cn, co);
			steady = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_WORDS);
		end
		steady = 1'b0;

		// Stream end comes last because only a reset can undo it. After it, scale
		// words and coded samples are dropped while preloads are still taken.
		push_word(tta_pkg::CMD_SCALE, 3'd0, tta_pkg::END_WORD, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd0, 16'h0003, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SCALE, 3'd2, 16'h0004, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_PRELOAD, 3'd3, 16'h0000, 16'h1234, 16'hEDCB);
		push_word(tta_pkg::CMD_SAMPLE, 3'd3, 16'h0001, 16'h0000, 16'h0000);
		push_word(tta_pkg::CMD_SAMPLE, 3'd2, 16'hFFFF, 16'h0000, 16'h0000);
		in_valid = 1'b0;

		// Wait for every owed sample, then give the pipeline time to show anything
		// extra it might still emit.
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4 * SETTLE) @(negedge clk);

		$display("Run sent %0d input words and made %0d register writes over %0d settings.",
			words_in, reg_writes, settings);
		$display("%0d decoded samples were compared, %0d of them wrong.",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("two_tap_adpcm_block_decoder_core verification clean");
		end else begin
			$display("two_tap_adpcm_block_decoder_core verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/tta_pkg.sv
hdl/tta_predict.sv
hdl/two_tap_adpcm_block_decoder_core.sv
sim/adpcm_decode_check_pkg.sv
sim/two_tap_adpcm_block_decoder_core_tb.sv
